@@ sv/spa_pkg.sv @@
// Shared types and codes for the source port pool allocator.
package spa_pkg;

   // Operation codes carried in the op field of a request.
   localparam logic [2:0] OP_FETCH       = 3'd0;
   localparam logic [2:0] OP_FREE        = 3'd1;
   localparam logic [2:0] OP_SPLICE      = 3'd2;
   localparam logic [2:0] OP_FREE_SPLICE = 3'd3;
   localparam logic [2:0] OP_SEARCH      = 3'd4;
   localparam logic [2:0] OP_INIT        = 3'd5;

   // Entry state codes held in the state memory.
   localparam logic [1:0] ST_ABSENT = 2'd0;
   localparam logic [1:0] ST_FREE   = 2'd1;
   localparam logic [1:0] ST_USED   = 2'd2;
   localparam logic [1:0] ST_SPLICE = 2'd3;

   // Configuration register indexes.
   localparam logic [0:0] CSR_BASE_ADDRESS  = 1'b0;
   localparam logic [0:0] CSR_ADDRESS_COUNT = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_INIT,
      S_RESP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic init_start;
      logic exec;
      logic init_step;
      logic init_finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic op_init;
      logic walk_end;
   } stat_type;

endpackage

@@ sv/spa_req_if.sv @@
// Request channel: op and the named address/port pair.
interface spa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] req_address;
   logic [15:0] req_port;

   modport source (output valid, output op, output req_address, output req_port,
                   input ready);
   modport sink (input valid, input op, input req_address, input req_port,
                 output ready);
endinterface

@@ sv/spa_rsp_if.sv @@
// Response channel: status, fetched pair and pool totals.
interface spa_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] got_address;
   logic [15:0] got_port;
   logic [12:0] free_count;
   logic [12:0] used_count;
   logic [12:0] splice_count;

   modport source (output valid, output status, output got_address, output got_port,
                   output free_count, output used_count, output splice_count,
                   input ready);
   modport sink (input valid, input status, input got_address, input got_port,
                 input free_count, input used_count, input splice_count,
                 output ready);
endinterface

@@ sv/spa_csr_if.sv @@
// Configuration write channel.
interface spa_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] write_data;

   modport source (output valid, output index, output write_data, input ready);
   modport sink (input valid, input index, input write_data, output ready);
endinterface

@@ sv/spa_ctrl.sv @@
// Controller state machine sequencing lookup, update, init walk and response.
module spa_ctrl
   import spa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = stat.op_init ? S_INIT : S_EXEC;
            end
         end
         S_EXEC: state_in = S_RESP;
         S_INIT: begin
            if (stat.walk_end) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready      = 1'b1;
            cmd.capture    = req_valid;
            cmd.init_start = req_valid & stat.op_init;
         end
         S_EXEC: cmd.exec = 1'b1;
         S_INIT: begin
            cmd.init_finish = stat.walk_end;
            cmd.init_step   = ~stat.walk_end;
         end
         S_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

@@ sv/spa_datapath.sv @@
// Datapath: config registers, entry state memory, free queue and totals.
module spa_datapath
   import spa_pkg::*;
#(
   parameter int MAX_ADDRESSES     = 4,
   parameter int PORT_LOW          = 1024,
   parameter int PORTS_PER_ADDRESS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [2:0]  op,
   input  logic [31:0] req_address,
   input  logic [15:0] req_port,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        status,
   output logic [31:0] got_address,
   output logic [15:0] got_port,
   output logic [12:0] free_count,
   output logic [12:0] used_count,
   output logic [12:0] splice_count
);

   localparam int SPAN = (PORT_LOW + PORTS_PER_ADDRESS > 65536) ?
                         65536 - PORT_LOW : PORTS_PER_ADDRESS;
   localparam int PI_W      = (SPAN > 1) ? $clog2(SPAN) : 1;
   localparam int AOFF_W    = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
   localparam int KEY_W     = AOFF_W + PI_W;
   localparam int ENTRY_CAP = MAX_ADDRESSES * PORTS_PER_ADDRESS;
   localparam int QPTR_W    = (ENTRY_CAP > 1) ? $clog2(ENTRY_CAP) : 1;
   localparam int CNT_W     = $clog2(ENTRY_CAP + 1);
   localparam int PA_W      = $clog2(MAX_ADDRESSES + 1);

   // config registers
   logic [31:0] base_address_ff;
   logic [2:0]  address_count_ff;

   // pool geometry latched at init
   logic [31:0]     pool_base_ff, pool_base_in;
   logic [PA_W-1:0] pool_addrs_ff, pool_addrs_in;

   // memories
   logic [1:0]       state_mem [2**KEY_W];
   logic [KEY_W-1:0] queue_mem [ENTRY_CAP];
   logic [1:0]       state_rd_ff;
   logic [KEY_W-1:0] queue_rd_ff;

   logic [QPTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  free_ff, free_in, used_ff, used_in, splice_ff, splice_in;

   // captured request
   logic [2:0]       op_ff;
   logic [KEY_W-1:0] key_ff;
   logic             found_ff;

   // init walk counters
   logic [PA_W-1:0] wa_ff, wa_in;
   logic [PI_W-1:0] wp_ff, wp_in;

   logic        status_ff, status_in;
   logic [31:0] got_address_ff, got_address_in;
   logic [15:0] got_port_ff, got_port_in;

   // request lookup
   logic [31:0]      off;
   logic [15:0]      pi16;
   logic             found;
   logic [KEY_W-1:0] req_key;
   logic [6:0]       cnt7;

   // memory write controls
   logic             st_we, q_we;
   logic [KEY_W-1:0] st_wkey;
   logic [1:0]       st_wval;

   logic [CNT_W+12:0] free_x, used_x, splice_x;

   function automatic logic [QPTR_W-1:0] wrap_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(ENTRY_CAP - 1)) ? '0 : p + 1'b1;
   endfunction

   assign off     = req_address - pool_base_ff;
   assign pi16    = req_port - 16'(PORT_LOW);
   assign found   = (off < 32'(pool_addrs_ff)) && (req_port >= 16'(PORT_LOW)) &&
                    ({1'b0, pi16} < 17'(SPAN));
   assign req_key = {off[AOFF_W-1:0], pi16[PI_W-1:0]};
   assign cnt7    = 7'(address_count_ff);

   assign stat.op_init  = (op == OP_INIT);
   assign stat.walk_end = (wa_ff == pool_addrs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff  <= '0;
         address_count_ff <= 3'd1;
      end else if (csr_write) begin
         if (csr_index == CSR_BASE_ADDRESS) begin
            base_address_ff <= csr_data;
         end
         if (csr_index == CSR_ADDRESS_COUNT) begin
            address_count_ff <= csr_data[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      state_rd_ff <= state_mem[req_key];
      queue_rd_ff <= queue_mem[head_ff];
      if (st_we) begin
         state_mem[st_wkey] <= st_wval;
      end
      if (q_we) begin
         queue_mem[tail_ff] <= st_wkey;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op;
         key_ff   <= req_key;
         found_ff <= found;
      end
   end

   always_comb begin
      pool_base_in   = pool_base_ff;
      pool_addrs_in  = pool_addrs_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      free_in        = free_ff;
      used_in        = used_ff;
      splice_in      = splice_ff;
      wa_in          = wa_ff;
      wp_in          = wp_ff;
      status_in      = status_ff;
      got_address_in = got_address_ff;
      got_port_in    = got_port_ff;
      st_we          = 1'b0;
      q_we           = 1'b0;
      st_wkey        = key_ff;
      st_wval        = ST_FREE;

      if (cmd.init_start) begin
         pool_base_in  = base_address_ff;
         pool_addrs_in = (cnt7 > 7'(MAX_ADDRESSES)) ? PA_W'(MAX_ADDRESSES) : PA_W'(cnt7);
         head_in       = '0;
         tail_in       = '0;
         free_in       = '0;
         used_in       = '0;
         splice_in     = '0;
         wa_in         = '0;
         wp_in         = '0;
      end

      if (cmd.init_step) begin
         st_we   = 1'b1;
         q_we    = 1'b1;
         st_wkey = {wa_ff[AOFF_W-1:0], wp_ff};
         st_wval = ST_FREE;
         tail_in = wrap_next(tail_ff);
         free_in = free_ff + 1'b1;
         if (wp_ff == PI_W'(SPAN - 1)) begin
            wp_in = '0;
            wa_in = wa_ff + 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end

      if (cmd.init_finish) begin
         status_in      = 1'b0;
         got_address_in = '0;
         got_port_in    = '0;
      end

      if (cmd.exec) begin
         status_in      = 1'b1;
         got_address_in = '0;
         got_port_in    = '0;
         case (op_ff)
            OP_FETCH: begin
               if (free_ff != '0) begin
                  st_we          = 1'b1;
                  st_wkey        = queue_rd_ff;
                  st_wval        = ST_USED;
                  head_in        = wrap_next(head_ff);
                  free_in        = free_ff - 1'b1;
                  used_in        = used_ff + 1'b1;
                  got_address_in = pool_base_ff + 32'(queue_rd_ff[KEY_W-1:PI_W]);
                  got_port_in    = 16'(PORT_LOW) + 16'(queue_rd_ff[PI_W-1:0]);
                  status_in      = 1'b0;
               end
            end
            OP_FREE: begin
               if (found_ff && state_rd_ff == ST_USED) begin
                  st_we     = 1'b1;
                  q_we      = 1'b1;
                  st_wval   = ST_FREE;
                  tail_in   = wrap_next(tail_ff);
                  free_in   = free_ff + 1'b1;
                  used_in   = used_ff - 1'b1;
                  status_in = 1'b0;
               end
            end
            OP_SPLICE: begin
               if (found_ff && state_rd_ff == ST_USED) begin
                  st_we     = 1'b1;
                  st_wval   = ST_SPLICE;
                  used_in   = used_ff - 1'b1;
                  splice_in = splice_ff + 1'b1;
                  status_in = 1'b0;
               end
            end
            OP_FREE_SPLICE: begin
               if (found_ff && state_rd_ff == ST_SPLICE) begin
                  st_we     = 1'b1;
                  q_we      = 1'b1;
                  st_wval   = ST_FREE;
                  tail_in   = wrap_next(tail_ff);
                  free_in   = free_ff + 1'b1;
                  splice_in = splice_ff - 1'b1;
                  status_in = 1'b0;
               end
            end
            OP_SEARCH: begin
               if (found_ff && state_rd_ff == ST_SPLICE) begin
                  status_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_addrs_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_ff       <= '0;
         used_ff       <= '0;
         splice_ff     <= '0;
         wa_ff         <= '0;
         wp_ff         <= '0;
      end else begin
         pool_base_ff  <= pool_base_in;
         pool_addrs_ff <= pool_addrs_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_ff       <= free_in;
         used_ff       <= used_in;
         splice_ff     <= splice_in;
         wa_ff         <= wa_in;
         wp_ff         <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      got_address_ff <= got_address_in;
      got_port_ff    <= got_port_in;
   end

   assign free_x   = {13'b0, free_ff};
   assign used_x   = {13'b0, used_ff};
   assign splice_x = {13'b0, splice_ff};

   assign status       = status_ff;
   assign got_address  = got_address_ff;
   assign got_port     = got_port_ff;
   assign free_count   = free_x[12:0];
   assign used_count   = used_x[12:0];
   assign splice_count = splice_x[12:0];

   // queue occupancy seen from the pointers
   logic [QPTR_W:0] occ;
   assign occ = (tail_ff >= head_ff) ? {1'b0, tail_ff} - {1'b0, head_ff} :
                {1'b0, tail_ff} + (QPTR_W + 1)'(ENTRY_CAP) - {1'b0, head_ff};

   a_totals_bounded: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 2)'(free_ff) + (CNT_W + 2)'(used_ff) + (CNT_W + 2)'(splice_ff)) <=
      (CNT_W + 2)'(ENTRY_CAP))
      else $error("pool totals exceed capacity");

   a_queue_matches_free: assert property (@(posedge clock) disable iff (reset)
      (free_ff == CNT_W'(ENTRY_CAP)) ? (head_ff == tail_ff) :
      ((CNT_W + 1)'(occ) == (CNT_W + 1)'(free_ff)))
      else $error("free queue pointers disagree with free total");

   a_fetch_pops: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == OP_FETCH && free_ff != '0) |=>
      (free_ff == $past(free_ff) - 1'b1) && (used_ff == $past(used_ff) + 1'b1))
      else $error("fetch did not move one entry from free to used");

   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.init_start |=> (used_ff == '0) && (splice_ff == '0) && (free_ff == '0))
      else $error("init did not clear totals");

endmodule

@@ sv/source_port_pool_allocator.sv @@
// A request is taken only while the block is idle. Fetch, free, splice, free-splice and
// search run as follows: the cycle that accepts the transfer reads the entry state memory
// and the free queue head, the exec state writes them back and updates the totals, and
// the response state presents the response until it is taken. Init walks every entry of
// the new pool through one state/queue write port, one entry a cycle, covering
// address_count (capped at MAX_ADDRESSES) times the port span entries. Before the first
// init the pool is empty and every op but init reports failure.
module source_port_pool_allocator
   import spa_pkg::*;
#(
   parameter int MAX_ADDRESSES     = 4,
   parameter int PORT_LOW          = 1024,
   parameter int PORTS_PER_ADDRESS = 1024
) (
   input logic       clock,
   input logic       reset,
   spa_req_if.sink   req_chan,
   spa_rsp_if.source rsp_chan,
   spa_csr_if.sink   csr_chan
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_chan.ready = 1'b1;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spa_datapath #(
      .MAX_ADDRESSES     (MAX_ADDRESSES),
      .PORT_LOW          (PORT_LOW),
      .PORTS_PER_ADDRESS (PORTS_PER_ADDRESS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .op           (req_chan.op),
      .req_address  (req_chan.req_address),
      .req_port     (req_chan.req_port),
      .csr_write    (csr_chan.valid),
      .csr_index    (csr_chan.index),
      .csr_data     (csr_chan.write_data),
      .status       (rsp_chan.status),
      .got_address  (rsp_chan.got_address),
      .got_port     (rsp_chan.got_port),
      .free_count   (rsp_chan.free_count),
      .used_count   (rsp_chan.used_count),
      .splice_count (rsp_chan.splice_count)
   );

endmodule
